>>> sv/aecb_pkg.sv
// ----------------------------------------------------------------------------
// aecb_pkg
// Shared types, constants and the neighbor mask function of the alpha edge
// color bleed block.
// ----------------------------------------------------------------------------
package aecb_pkg;

   localparam int WIDTH_BITS  = 11;
   localparam int HEIGHT_BITS = 13;
   localparam int PIXEL_BITS  = 32;
   localparam int COLOR_BITS  = 24;
   localparam int LINE_BITS   = 2 * PIXEL_BITS;

   localparam logic [7:0] ALPHA_FULL = 8'hff;
   localparam logic [7:0] ALPHA_ZERO = 8'h00;

   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd64;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd64;

   // command codes of an input beat
   localparam logic CMD_PIXEL = 1'b0;

   // register indexes on the csr port
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // neighbor priority, position 0 is tried first
   localparam int NUM_DIRS = 8;
   localparam int DIR_U    = 0;
   localparam int DIR_L    = 1;
   localparam int DIR_R    = 2;
   localparam int DIR_UL   = 3;
   localparam int DIR_UR   = 4;
   localparam int DIR_DL   = 5;
   localparam int DIR_DR   = 6;
   localparam int DIR_D    = 7;

   localparam int FIFO_DEPTH     = 4;
   localparam int FIFO_PTR_BITS  = 2;
   localparam int FIFO_CNT_BITS  = 3;
   localparam int OCC_BITS       = 4;

   typedef enum logic [1:0] {
      POS_FIRST,
      POS_MID,
      POS_LAST
   } pos_type;

   typedef struct packed {
      logic    adv;     // shifts the window and touches the line memory
      logic    emit;    // produces a result beat
      logic    thin;    // pass-through beat of a one-row or one-column image
      logic    last;    // final result of the image
      logic    first;   // center is the first pixel of the image
      pos_type row_pos;
      pos_type col_pos;
   } item_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic                  last;
      logic                  masked;
   } result_type;

   // which neighbors a pixel may borrow from, by its place in the image
   function automatic logic [NUM_DIRS-1:0] nb_mask(input pos_type row_pos,
                                                   input pos_type col_pos);
      logic [NUM_DIRS-1:0] m;
      logic                inner;
      m             = '0;
      inner         = (row_pos == POS_MID) && (col_pos == POS_MID);
      m[DIR_U]      = (row_pos != POS_FIRST);
      m[DIR_D]      = (row_pos != POS_LAST);
      m[DIR_L]      = (col_pos != POS_FIRST);
      m[DIR_R]      = (col_pos != POS_LAST);
      m[DIR_UL]     = inner;
      m[DIR_UR]     = inner;
      m[DIR_DL]     = inner;
      m[DIR_DR]     = inner;
      return m;
   endfunction

endpackage

>>> sv/aecb_line_mem.sv
// ----------------------------------------------------------------------------
// aecb_line_mem
// Two-line buffer: one entry per column holds the pixel one row up and the
// pixel two rows up. Synchronous read: the read data is registered.
// ----------------------------------------------------------------------------
module aecb_line_mem #(
   parameter int DEPTH     = 1024,
   parameter int ADDR_BITS = 10,
   parameter int DATA_BITS = 64
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data_ff,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

>>> sv/aecb_window.sv
// ----------------------------------------------------------------------------
// aecb_window
// 3x3 pixel window fed from the line memory, neighbor selection for
// transparent pixels and the image transparency flags.
// ----------------------------------------------------------------------------
module aecb_window (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  flag_clear,
   input  logic                                  s1_valid,
   input  aecb_pkg::item_type                    s1_item,
   input  logic [aecb_pkg::PIXEL_BITS-1:0]       s1_pixel,
   input  logic [aecb_pkg::LINE_BITS-1:0]        line_data,
   output logic                                  s2_busy,
   output logic                                  res_valid,
   output aecb_pkg::result_type                  res
);

   logic [aecb_pkg::PIXEL_BITS-1:0] win_ff [3][3];
   logic                            s2_valid_ff;
   aecb_pkg::item_type              s2_item_ff;
   logic [aecb_pkg::PIXEL_BITS-1:0] s2_pix_ff;
   logic                            saw_trans_ff;
   logic                            saw_semi_ff;

   logic [aecb_pkg::PIXEL_BITS-1:0] nb [aecb_pkg::NUM_DIRS];
   logic [aecb_pkg::NUM_DIRS-1:0]   mask;
   logic [aecb_pkg::PIXEL_BITS-1:0] center;
   logic [aecb_pkg::PIXEL_BITS-1:0] fill;
   logic                            found;
   logic                            is_clear;
   logic                            is_semi;
   logic                            trans_in;
   logic                            semi_in;
   logic                            normal_emit;

   always_ff @(posedge clock) begin
      if (s1_valid && s1_item.adv) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         // right column: two rows up, one row up, incoming pixel
         win_ff[0][2] <= line_data[aecb_pkg::PIXEL_BITS-1:0];
         win_ff[1][2] <= line_data[aecb_pkg::LINE_BITS-1:aecb_pkg::PIXEL_BITS];
         win_ff[2][2] <= s1_pixel;
      end
      s2_item_ff <= s1_item;
      s2_pix_ff  <= s1_pixel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         saw_trans_ff <= 1'b0;
         saw_semi_ff  <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid;
         if (flag_clear) begin
            saw_trans_ff <= 1'b0;
            saw_semi_ff  <= 1'b0;
         end else if (normal_emit) begin
            if (s2_item_ff.last) begin
               saw_trans_ff <= 1'b0;
               saw_semi_ff  <= 1'b0;
            end else begin
               saw_trans_ff <= trans_in;
               saw_semi_ff  <= semi_in;
            end
         end
      end
   end

   always_comb begin
      nb[aecb_pkg::DIR_U]  = win_ff[0][1];
      nb[aecb_pkg::DIR_L]  = win_ff[1][0];
      nb[aecb_pkg::DIR_R]  = win_ff[1][2];
      nb[aecb_pkg::DIR_UL] = win_ff[0][0];
      nb[aecb_pkg::DIR_UR] = win_ff[0][2];
      nb[aecb_pkg::DIR_DL] = win_ff[2][0];
      nb[aecb_pkg::DIR_DR] = win_ff[2][2];
      nb[aecb_pkg::DIR_D]  = win_ff[2][1];
      mask   = aecb_pkg::nb_mask(s2_item_ff.row_pos, s2_item_ff.col_pos);
      center = win_ff[1][1];
      found  = 1'b0;
      fill   = center;
      // first fully opaque neighbor in priority order wins
      for (int k = 0; k < aecb_pkg::NUM_DIRS; k++) begin
         if (!found && mask[k] &&
             (nb[k][aecb_pkg::PIXEL_BITS-1:aecb_pkg::COLOR_BITS] ==
              aecb_pkg::ALPHA_FULL)) begin
            found = 1'b1;
            fill  = {aecb_pkg::ALPHA_ZERO, nb[k][aecb_pkg::COLOR_BITS-1:0]};
         end
      end
      is_clear = center[aecb_pkg::PIXEL_BITS-1:aecb_pkg::COLOR_BITS] ==
                 aecb_pkg::ALPHA_ZERO;
      is_semi  = !is_clear &&
                 (center[aecb_pkg::PIXEL_BITS-1:aecb_pkg::COLOR_BITS] != aecb_pkg::ALPHA_FULL);
      trans_in = saw_trans_ff || (is_clear && (found || s2_item_ff.first));
      semi_in  = saw_semi_ff || is_semi;

      res_valid   = s2_valid_ff && s2_item_ff.emit;
      normal_emit = res_valid && !s2_item_ff.thin;
      res.last    = s2_item_ff.last;
      if (s2_item_ff.thin) begin
         res.pixel  = s2_pix_ff;
         res.masked = 1'b0;
      end else begin
         // only a fully transparent center borrows a color
         res.pixel  = is_clear ? fill : center;
         res.masked = s2_item_ff.last && (trans_in || semi_in);
      end
   end

   assign s2_busy = s2_valid_ff;

endmodule

>>> sv/aecb_out_fifo.sv
// ----------------------------------------------------------------------------
// aecb_out_fifo
// Small result queue between the window pipeline and the result channel.
// ----------------------------------------------------------------------------
module aecb_out_fifo (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  aecb_pkg::result_type                 push_data,
   input  logic                                 out_stall,
   output logic                                 out_valid,
   output aecb_pkg::result_type                 head,
   output logic [aecb_pkg::FIFO_CNT_BITS-1:0]   count_in
);

   aecb_pkg::result_type                   mem_ff [aecb_pkg::FIFO_DEPTH];
   logic [aecb_pkg::FIFO_PTR_BITS-1:0]     wr_ptr_ff;
   logic [aecb_pkg::FIFO_PTR_BITS-1:0]     rd_ptr_ff;
   logic [aecb_pkg::FIFO_CNT_BITS-1:0]     count_ff;
   logic                                   pop;

   assign out_valid = count_ff != '0;
   assign head      = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + aecb_pkg::FIFO_CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - aecb_pkg::FIFO_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + aecb_pkg::FIFO_PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + aecb_pkg::FIFO_PTR_BITS'(1);
         end
      end
   end

endmodule

>>> sv/alpha_edge_color_bleed_core.sv
// ----------------------------------------------------------------------------
// alpha_edge_color_bleed_core
// Streams 32-bit pixels in raster order and gives every fully transparent
// pixel the color of its first fully opaque neighbor in the 3x3 window
// (diagonals only for interior pixels).
// One beat is taken every clock cycle while req_stall is low, pixel and flush
// beats alike; a result passes the line memory read, the window register and
// the result queue on its way out. Results trail the pixel stream by
// image_width+1 beats, so after the last pixel of an image the same number of
// flush beats (or further pixel beats, whose data is dropped) drains the tail.
// The two previous rows sit in one MAX_WIDTH x 64 line memory that needs no
// clearing after reset. Images of width or height 1 pass straight through
// with masked 0. Any register write starts a new image; registers are to be
// written only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module alpha_edge_color_bleed_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [31:0] req_pixel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pixel_out,
   output logic        rsp_last,
   output logic        rsp_masked,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int ROW_BITS = $clog2(MAX_HEIGHT);
   localparam int WB       = aecb_pkg::WIDTH_BITS;
   localparam int HB       = aecb_pkg::HEIGHT_BITS;

   // configuration
   logic [WB-1:0] width_ff;
   logic [HB-1:0] height_ff;
   logic [WB-1:0] eff_width;
   logic [HB-1:0] eff_height;
   logic          cfg_wr;
   logic          thin;
   logic [COL_BITS-1:0] last_col;
   logic [ROW_BITS-1:0] last_row;

   // position counters
   logic [COL_BITS-1:0] in_col_ff, in_col_in;
   logic [ROW_BITS-1:0] in_row_ff, in_row_in;
   logic                in_done_ff, in_done_in;
   logic [COL_BITS-1:0] out_col_ff, out_col_in;
   logic [ROW_BITS-1:0] out_row_ff, out_row_in;

   logic                req_stall_ff, req_stall_in;
   logic                accept;
   logic                is_pixel;
   logic                in_last;
   logic                out_last;
   logic                primed;
   logic                stream;
   logic                drain;
   aecb_pkg::item_type  item;

   // stage 1: line memory read in flight
   logic                             s1_valid_ff;
   aecb_pkg::item_type               s1_item_ff;
   logic [aecb_pkg::PIXEL_BITS-1:0]  s1_pix_ff;
   logic [COL_BITS-1:0]              s1_addr_ff;
   logic [aecb_pkg::LINE_BITS-1:0]   line_data;

   logic                                  s2_busy;
   logic                                  res_valid;
   aecb_pkg::result_type                  res;
   aecb_pkg::result_type                  head;
   logic [aecb_pkg::FIFO_CNT_BITS-1:0]    fifo_count_in;
   logic [aecb_pkg::OCC_BITS-1:0]         occ;

   // ---------------------------------------------------------------- csr
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      if (csr_paddr[2] == aecb_pkg::REG_HEIGHT) begin
         csr_prdata = {{(32-HB){1'b0}}, height_ff};
      end else begin
         csr_prdata = {{(32-WB){1'b0}}, width_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= aecb_pkg::WIDTH_RESET;
         height_ff <= aecb_pkg::HEIGHT_RESET;
      end else if (cfg_wr) begin
         if (csr_paddr[2] == aecb_pkg::REG_WIDTH) begin
            width_ff <= csr_pwdata[WB-1:0];
         end else begin
            height_ff <= csr_pwdata[HB-1:0];
         end
      end
   end

   // saturate the image size to MAX_WIDTH and MAX_HEIGHT, a size of 0 counts as 1
   always_comb begin
      eff_width = width_ff;
      if (width_ff == '0) begin
         eff_width = WB'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_width = WB'(MAX_WIDTH);
      end
      eff_height = height_ff;
      if (height_ff == '0) begin
         eff_height = HB'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         eff_height = HB'(MAX_HEIGHT);
      end
   end

   assign thin     = (eff_width == WB'(1)) || (eff_height == HB'(1));
   assign last_col = COL_BITS'(eff_width - WB'(1));
   assign last_row = ROW_BITS'(eff_height - HB'(1));

   // ---------------------------------------------------------------- decode
   assign accept   = req_valid && !req_stall_ff;
   assign is_pixel = req_cmd == aecb_pkg::CMD_PIXEL;
   assign in_last  = (in_row_ff == last_row) && (in_col_ff == last_col);
   assign out_last = (out_row_ff == last_row) && (out_col_ff == last_col);
   // output starts once one row and one pixel are in
   assign primed   = (in_row_ff != '0) && !((in_row_ff == ROW_BITS'(1)) && (in_col_ff == '0));
   assign stream   = !thin && is_pixel && !in_done_ff;
   assign drain    = !thin && in_done_ff;

   always_comb begin
      item.thin  = thin && is_pixel;
      item.adv   = stream || drain;
      item.emit  = (stream && primed) || drain || (thin && is_pixel);
      item.last  = thin ? in_last : out_last;
      item.first = (out_row_ff == '0) && (out_col_ff == '0);
      if (out_row_ff == '0) begin
         item.row_pos = aecb_pkg::POS_FIRST;
      end else if (out_row_ff == last_row) begin
         item.row_pos = aecb_pkg::POS_LAST;
      end else begin
         item.row_pos = aecb_pkg::POS_MID;
      end
      if (out_col_ff == '0) begin
         item.col_pos = aecb_pkg::POS_FIRST;
      end else if (out_col_ff == last_col) begin
         item.col_pos = aecb_pkg::POS_LAST;
      end else begin
         item.col_pos = aecb_pkg::POS_MID;
      end
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      in_done_in = in_done_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (accept) begin
         if (item.thin) begin
            if (in_last) begin
               in_col_in = '0;
               in_row_in = '0;
            end else if (in_col_ff == last_col) begin
               in_col_in = '0;
               in_row_in = in_row_ff + ROW_BITS'(1);
            end else begin
               in_col_in = in_col_ff + COL_BITS'(1);
            end
         end else begin
            // the column keeps counting through the drain to address the memory
            if (item.adv) begin
               if (in_col_ff == last_col) begin
                  in_col_in = '0;
               end else begin
                  in_col_in = in_col_ff + COL_BITS'(1);
               end
            end
            if (stream && (in_col_ff == last_col)) begin
               if (in_last) begin
                  in_done_in = 1'b1;
               end else begin
                  in_row_in = in_row_ff + ROW_BITS'(1);
               end
            end
            if (item.emit) begin
               if (out_last) begin
                  in_col_in  = '0;
                  in_row_in  = '0;
                  in_done_in = 1'b0;
                  out_col_in = '0;
                  out_row_in = '0;
               end else if (out_col_ff == last_col) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + ROW_BITS'(1);
               end else begin
                  out_col_in = out_col_ff + COL_BITS'(1);
               end
            end
         end
      end
      if (cfg_wr) begin
         in_col_in  = '0;
         in_row_in  = '0;
         in_done_in = 1'b0;
         out_col_in = '0;
         out_row_in = '0;
      end
   end

   // beats in flight plus queued results must fit the result queue
   assign occ          = aecb_pkg::OCC_BITS'(fifo_count_in) + aecb_pkg::OCC_BITS'(accept) +
                         aecb_pkg::OCC_BITS'(s1_valid_ff);
   assign req_stall_in = occ >= aecb_pkg::OCC_BITS'(aecb_pkg::FIFO_DEPTH);
   assign req_stall    = req_stall_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_done_ff   <= 1'b0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         req_stall_ff <= 1'b1;
         s1_valid_ff  <= 1'b0;
      end else begin
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         in_done_ff   <= in_done_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         req_stall_ff <= req_stall_in;
         s1_valid_ff  <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= item;
      s1_pix_ff  <= req_pixel;
      s1_addr_ff <= in_col_ff;
   end

   // ---------------------------------------------------------------- datapath
   aecb_line_mem #(
      .DEPTH     (MAX_WIDTH),
      .ADDR_BITS (COL_BITS),
      .DATA_BITS (aecb_pkg::LINE_BITS)
   ) u_line_mem (
      .clock      (clock),
      .rd_en      (accept && item.adv),
      .rd_addr    (in_col_ff),
      .rd_data_ff (line_data),
      .wr_en      (s1_valid_ff && s1_item_ff.adv),
      .wr_addr    (s1_addr_ff),
      // the row above moves down to two rows above
      .wr_data    ({s1_pix_ff, line_data[aecb_pkg::LINE_BITS-1:aecb_pkg::PIXEL_BITS]})
   );

   aecb_window u_window (
      .clock      (clock),
      .reset      (reset),
      .flag_clear (cfg_wr),
      .s1_valid   (s1_valid_ff),
      .s1_item    (s1_item_ff),
      .s1_pixel   (s1_pix_ff),
      .line_data  (line_data),
      .s2_busy    (s2_busy),
      .res_valid  (res_valid),
      .res        (res)
   );

   aecb_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid && s2_busy),
      .push_data (res),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .head      (head),
      .count_in  (fifo_count_in)
   );

   assign rsp_pixel_out = head.pixel;
   assign rsp_last      = head.last;
   assign rsp_masked    = head.masked;

endmodule

>>> sv/aecb_checker.sv
// ----------------------------------------------------------------------------
// aecb_checker
// Port-level checks of the alpha edge color bleed core, bound to the top.
// ----------------------------------------------------------------------------
module aecb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_pixel_out,
   input logic        rsp_last,
   input logic        rsp_masked
);

   // the transparency summary only rides on the final beat of an image
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_masked || rsp_last))
      else $error("masked set on a beat that is not last");

   // reset empties the result queue
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // a run of result beats starts only after an accepted input beat
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 3))
      else $error("result beat without a matching input beat");

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_pixel_out) && $stable(rsp_last) && $stable(rsp_masked)))
      else $error("stalled result beat changed");

endmodule

bind alpha_edge_color_bleed_core aecb_checker u_aecb_checker (.*);

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for alpha_edge_color_bleed_core. Images of many sizes,
// including the saturated and one-row/one-column extremes, are streamed with
// random content, early flushes, pixel beats used as drain beats and
// abandoned images. A local model of the bleed predicts every result beat,
// and each beat leaving the block is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic CMD_FLUSH   = 1'b1;
   localparam int   MAX_COLS    = 1024;
   localparam int   MAX_ROWS    = 4096;
   localparam int   STORE_DEPTH = 2 * MAX_COLS + 2;
   localparam int   IDLE_CYCLES = 8;
   localparam int   TAIL_CYCLES = 20;
   localparam int   RANDOM_BEATS = 360;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_cmd = aecb_pkg::CMD_PIXEL;
   logic [31:0] req_pixel = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_pixel_out;
   logic        rsp_last;
   logic        rsp_masked;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // shadow registers and stream state of the local model
   logic [aecb_pkg::WIDTH_BITS-1:0]  cols_reg = aecb_pkg::WIDTH_RESET;
   logic [aecb_pkg::HEIGHT_BITS-1:0] rows_reg = aecb_pkg::HEIGHT_RESET;
   logic [31:0]            orig_rows [STORE_DEPTH];
   int unsigned            px_taken = 0;
   int unsigned            px_given = 0;
   bit                     saw_clear = 1'b0;
   bit                     saw_semi = 1'b0;
   aecb_pkg::result_type   bled_results_due [$];

   int mismatches = 0;
   int beats_sent = 0;
   int tx_gap_max = 4;
   int rx_gap_max = 4;
   int rx_wait = 0;
   int hold_left = 0;

   alpha_edge_color_bleed_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_pixel     (req_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_last      (rsp_last),
      .rsp_masked    (rsp_masked),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // model of the bleed
   // ------------------------------------------------------------------
   function automatic int unsigned cur_cols();
      if (cols_reg == 0) return 1;
      if (cols_reg > MAX_COLS) return MAX_COLS;
      return 32'(cols_reg);
   endfunction

   function automatic int unsigned cur_rows();
      if (rows_reg == 0) return 1;
      if (rows_reg > MAX_ROWS) return MAX_ROWS;
      return 32'(rows_reg);
   endfunction

   function automatic void restart_image();
      px_taken  = 0;
      px_given  = 0;
      saw_clear = 1'b0;
      saw_semi  = 1'b0;
   endfunction

   function automatic void queue_result(aecb_pkg::result_type res);
      bled_results_due.insert(bled_results_due.size(), res);
   endfunction

   // the beat being accepted is not in the store yet
   function automatic logic [31:0] window_px(int unsigned q, bit has_cur,
                                             logic [31:0] cur);
      if (has_cur && q == px_taken) return cur;
      return orig_rows[q % STORE_DEPTH];
   endfunction

   function automatic aecb_pkg::result_type bleed_next(bit has_cur, logic [31:0] cur);
      int unsigned          w, h, p, r, c, q;
      int                   nr, nc, dr, dc, k;
      bit                   interior, found;
      logic [31:0]          px, nb;
      aecb_pkg::result_type res;
      w = cur_cols();
      h = cur_rows();
      p = px_given;
      r = p / w;
      c = p % w;
      px = window_px(p, has_cur, cur);
      res.pixel = px;
      found = 1'b0;
      if (px[31:24] == aecb_pkg::ALPHA_ZERO) begin
         if (p == 0) saw_clear = 1'b1;
         // diagonals only count away from every border
         interior = (r > 0) && (r < h - 1) && (c > 0) && (c < w - 1);
         for (k = 0; k < aecb_pkg::NUM_DIRS; k++) begin
            case (k)
               aecb_pkg::DIR_U:  begin dr = -1; dc = 0;  end
               aecb_pkg::DIR_L:  begin dr = 0;  dc = -1; end
               aecb_pkg::DIR_R:  begin dr = 0;  dc = 1;  end
               aecb_pkg::DIR_UL: begin dr = -1; dc = -1; end
               aecb_pkg::DIR_UR: begin dr = -1; dc = 1;  end
               aecb_pkg::DIR_DL: begin dr = 1;  dc = -1; end
               aecb_pkg::DIR_DR: begin dr = 1;  dc = 1;  end
               default:          begin dr = 1;  dc = 0;  end
            endcase
            nr = int'(r) + dr;
            nc = int'(c) + dc;
            if (!found && nr >= 0 && nr < int'(h) && nc >= 0 && nc < int'(w)
                && (interior || dr == 0 || dc == 0)) begin
               q  = nr * int'(w) + nc;
               nb = window_px(q, has_cur, cur);
               if (nb[31:24] == aecb_pkg::ALPHA_FULL) begin
                  res.pixel = {aecb_pkg::ALPHA_ZERO, nb[23:0]};
                  saw_clear = 1'b1;
                  found     = 1'b1;
               end
            end
         end
      end else if (px[31:24] != aecb_pkg::ALPHA_FULL) begin
         saw_semi = 1'b1;
      end
      px_given++;
      res.last   = (px_given == w * h);
      res.masked = res.last && (saw_clear || saw_semi);
      if (res.last) restart_image();
      return res;
   endfunction

   function automatic void take_beat(logic cmd, logic [31:0] pix);
      int unsigned          w, h, total;
      aecb_pkg::result_type res;
      w = cur_cols();
      h = cur_rows();
      total = w * h;
      if (w == 1 || h == 1) begin
         if (cmd == aecb_pkg::CMD_PIXEL) begin
            px_taken++;
            res.pixel  = pix;
            res.last   = (px_taken >= total);
            res.masked = 1'b0;
            queue_result(res);
            if (res.last) restart_image();
            else px_given = px_taken;
         end
      end else if (cmd == aecb_pkg::CMD_PIXEL && px_taken < total) begin
         if (px_taken >= w + 1) queue_result(bleed_next(1'b1, pix));
         orig_rows[px_taken % STORE_DEPTH] = pix;
         px_taken++;
      end else if (px_taken == total && px_given < total) begin
         // drain beat, a late pixel beat loses its data
         queue_result(bleed_next(1'b0, '0));
      end
   endfunction

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------
   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch_results
      aecb_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (bled_results_due.size() == 0) begin
            flag_mismatch("beat with nothing due", rsp_pixel_out, '0);
         end else begin
            want = bled_results_due[0];
            bled_results_due.delete(0);
            if (rsp_pixel_out !== want.pixel)
               flag_mismatch("pixel_out", rsp_pixel_out, want.pixel);
            if (rsp_last !== want.last)
               flag_mismatch("last", 32'(rsp_last), 32'(want.last));
            if (rsp_masked !== want.masked)
               flag_mismatch("masked", 32'(rsp_masked), 32'(want.masked));
         end
         rx_wait = $urandom_range(0, rx_gap_max);
      end
   end

   // receiver stalls, long hold-offs counted here
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else if (rx_wait != 0) begin
         rsp_stall = 1'b1;
         rx_wait--;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------
   task automatic offer_beat(input logic cmd, input logic [31:0] pix);
      int unsigned gap;
      gap = $urandom_range(0, tx_gap_max);
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_cmd   = cmd;
      req_pixel = pix;
      do @(posedge clock); while (req_stall);
      take_beat(cmd, pix);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (bled_results_due.size() != 0) @(negedge clock);
      repeat (IDLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_cycle(input logic wr, input logic idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = wr;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = wdata;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic check_reg(input logic idx);
      logic [31:0] rd, want;
      csr_cycle(1'b0, idx, '0, rd);
      want = (idx == aecb_pkg::REG_WIDTH) ? 32'(cols_reg) : 32'(rows_reg);
      if (rd !== want) flag_mismatch("register readback", rd, want);
   endtask

   // any write drops the image in progress
   task automatic set_reg(input logic idx, input int unsigned value);
      logic [31:0] rd;
      wait_idle();
      csr_cycle(1'b1, idx, value, rd);
      if (idx == aecb_pkg::REG_WIDTH) cols_reg = value[aecb_pkg::WIDTH_BITS-1:0];
      else rows_reg = value[aecb_pkg::HEIGHT_BITS-1:0];
      restart_image();
      check_reg(idx);
   endtask

   function automatic logic [31:0] draw_pixel(bit opaque_only);
      logic [7:0] alpha;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: alpha = aecb_pkg::ALPHA_ZERO;
         4, 5, 6, 7: alpha = aecb_pkg::ALPHA_FULL;
         default:    alpha = 8'($urandom_range(0, 255));
      endcase
      if (opaque_only) alpha = aecb_pkg::ALPHA_FULL;
      return {alpha, 24'($urandom)};
   endfunction

   // one image at the current size, drained unless cut short
   task automatic stream_image(input bit opaque_only, input bit cut_short);
      int unsigned w, h, total, cut, n;
      bit          thin;
      w = cur_cols();
      h = cur_rows();
      total = w * h;
      thin = (w == 1 || h == 1);
      cut = (cut_short && total > 2) ? $urandom_range(1, total - 1) : total;
      for (n = 0; n < cut; n++) begin
         if ($urandom_range(0, 19) == 0) offer_beat(CMD_FLUSH, $urandom);
         offer_beat(aecb_pkg::CMD_PIXEL, draw_pixel(opaque_only));
         beats_sent++;
      end
      if (cut == total && !thin) begin
         repeat (w + 1) begin
            offer_beat($urandom_range(0, 1) ? CMD_FLUSH : aecb_pkg::CMD_PIXEL, $urandom);
            beats_sent++;
         end
      end
      if ($urandom_range(0, 3) == 0) offer_beat(CMD_FLUSH, $urandom);
      if (cut != total) set_reg(aecb_pkg::REG_WIDTH, cols_reg);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_reset_values();
      check_reg(aecb_pkg::REG_WIDTH);
      check_reg(aecb_pkg::REG_HEIGHT);
   endtask

   task automatic test_small_image();
      set_reg(aecb_pkg::REG_WIDTH, 3);
      set_reg(aecb_pkg::REG_HEIGHT, 3);
      offer_beat(aecb_pkg::CMD_PIXEL, 32'h00112233);
      offer_beat(aecb_pkg::CMD_PIXEL, 32'h7fa0a0a0);
      offer_beat(aecb_pkg::CMD_PIXEL, 32'h00000000);
      offer_beat(aecb_pkg::CMD_PIXEL, 32'hff0000ff);
      offer_beat(CMD_FLUSH, 32'hffffffff);   // too early, ignored
      offer_beat(aecb_pkg::CMD_PIXEL, 32'h00abcdef);
      offer_beat(aecb_pkg::CMD_PIXEL, 32'h80123456);
      offer_beat(aecb_pkg::CMD_PIXEL, 32'h00ffffff);
      offer_beat(aecb_pkg::CMD_PIXEL, 32'h0000ff00);
      offer_beat(aecb_pkg::CMD_PIXEL, 32'hffffffff);
      offer_beat(CMD_FLUSH, 32'h00000000);
      offer_beat(CMD_FLUSH, 32'h00000000);
      offer_beat(aecb_pkg::CMD_PIXEL, 32'hdeadbeef);   // past the image, acts as a flush
      offer_beat(CMD_FLUSH, 32'h12345678);
      offer_beat(CMD_FLUSH, 32'h00000000);   // nothing left to drain
   endtask

   task automatic test_thin_images();
      set_reg(aecb_pkg::REG_WIDTH, 0);
      set_reg(aecb_pkg::REG_HEIGHT, 3);
      offer_beat(aecb_pkg::CMD_PIXEL, 32'hffffffff);
      offer_beat(CMD_FLUSH, 32'h00000000);
      offer_beat(aecb_pkg::CMD_PIXEL, 32'h00000000);
      offer_beat(aecb_pkg::CMD_PIXEL, 32'h80808080);
   endtask

   task automatic test_size_extremes();
      // saturated width: the first row is still filling when the image is dropped
      set_reg(aecb_pkg::REG_WIDTH, 2047);
      set_reg(aecb_pkg::REG_HEIGHT, 2);
      repeat (40) offer_beat(aecb_pkg::CMD_PIXEL, draw_pixel(1'b0));
      set_reg(aecb_pkg::REG_WIDTH, 1);
      set_reg(aecb_pkg::REG_HEIGHT, 8191);
      repeat (30) offer_beat(aecb_pkg::CMD_PIXEL, draw_pixel(1'b0));
      set_reg(aecb_pkg::REG_HEIGHT, 0);
      set_reg(aecb_pkg::REG_WIDTH, 5);
      stream_image(1'b0, 1'b0);
      set_reg(aecb_pkg::REG_WIDTH, 2);
      set_reg(aecb_pkg::REG_HEIGHT, 2);
      stream_image(1'b0, 1'b0);
   endtask

   task automatic test_backpressure();
      set_reg(aecb_pkg::REG_WIDTH, 6);
      set_reg(aecb_pkg::REG_HEIGHT, 5);
      tx_gap_max = 0;
      hold_left  = 300;
      stream_image(1'b0, 1'b0);
      tx_gap_max = 4;
   endtask

   task automatic test_random_images();
      int unsigned wr, hr;
      int          start, pick;
      start = beats_sent;
      while (beats_sent - start < RANDOM_BEATS) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            wr = $urandom_range(2, 9);
            hr = $urandom_range(2, 6);
         end else if (pick == 7) begin
            wr = $urandom_range(0, 1);
            hr = $urandom_range(0, 8);
         end else if (pick == 8) begin
            wr = $urandom_range(2, 8);
            hr = $urandom_range(0, 1);
         end else begin
            wr = $urandom_range(10, 40);
            hr = $urandom_range(2, 3);
         end
         if (wr != cols_reg || $urandom_range(0, 3) == 0) set_reg(aecb_pkg::REG_WIDTH, wr);
         if (hr != rows_reg) set_reg(aecb_pkg::REG_HEIGHT, hr);
         tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
         rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
         stream_image($urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0);
      end
      tx_gap_max = 4;
      rx_gap_max = 4;
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset = 1'b0;
      test_reset_values();
      test_small_image();
      test_thin_images();
      test_size_extremes();
      test_backpressure();
      test_random_images();
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS alpha_edge_color_bleed_core");
      end else begin
         $display("FAIL alpha_edge_color_bleed_core");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL alpha_edge_color_bleed_core");
      $finish;
   end

endmodule

>>> sim.f
sv/aecb_pkg.sv
sv/aecb_line_mem.sv
sv/aecb_window.sv
sv/aecb_out_fifo.sv
sv/alpha_edge_color_bleed_core.sv
sv/aecb_checker.sv
test/tb.sv
